// ----- rtl/pdf_token_lexer_macros.svh -----
// assertion macros for the pdf token lexer
`ifndef PDF_TOKEN_LEXER_MACROS_SVH
`define PDF_TOKEN_LEXER_MACROS_SVH

`ifndef ASSERT_OFF
`define PTL_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define PTL_ASSERT(name, clk, rst_n, prop, msg)
`define PTL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/ptl_pkg.sv -----
`timescale 1ns / 1ps

package ptl_pkg;

    localparam int MAX_RESULTS = 3;
    localparam int COUNT_BITS  = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_FF      = 8'h0c;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_POINT   = 8'h2e;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LT      = 8'h3c;
    localparam logic [7:0] CH_GT      = 8'h3e;
    localparam logic [7:0] CH_LBRACK  = 8'h5b;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_RBRACK  = 8'h5d;
    localparam logic [7:0] CH_LBRACE  = 8'h7b;
    localparam logic [7:0] CH_RBRACE  = 8'h7d;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_SAT     = 2'd2;

    localparam logic [4:0] FRAC_MAX = 5'd31;

    typedef enum logic [3:0] {
        KIND_BAD     = 4'd0,
        KIND_KEYWORD = 4'd1,
        KIND_NAME    = 4'd2,
        KIND_STRING  = 4'd3,
        KIND_HEX     = 4'd4,
        KIND_NUMBER  = 4'd5,
        KIND_ABEGIN  = 4'd6,
        KIND_AEND    = 4'd7,
        KIND_DBEGIN  = 4'd8,
        KIND_DEND    = 4'd9,
        KIND_END     = 4'd10
    } token_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        token_kind_t token_kind;
        logic [31:0] start_offset;
        logic [31:0] token_length;
        logic [31:0] number_value;
        logic [4:0]  fraction_digits;
        logic        is_real;
        logic [1:0]  number_status;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]          count;
        result_t [MAX_RESULTS-1:0]      items;
    } batch_t;

    function automatic logic is_space(logic [7:0] c);
        return c inside {CH_NUL, CH_TAB, CH_LF, CH_FF, CH_CR, CH_SPACE};
    endfunction

    function automatic logic is_delim(logic [7:0] c);
        return c inside {CH_LPAREN, CH_RPAREN, CH_LT, CH_GT, CH_LBRACK, CH_RBRACK,
                         CH_LBRACE, CH_RBRACE, CH_SLASH, CH_PERCENT};
    endfunction

    function automatic logic is_numchar(logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE], CH_PLUS, CH_MINUS, CH_POINT};
    endfunction

endpackage

// ----- rtl/ptl_in_skid.sv -----
`timescale 1ns / 1ps

module ptl_in_skid
    import ptl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  in_item_t s_item,
    input  logic     take_i,
    output logic     valid_o,
    output in_item_t item_o
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_tready = !valid_reg || take_i;

    always_comb begin
        valid_next = valid_reg;
        if (take_i) begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign valid_o = valid_reg;
    assign item_o  = item_reg;

endmodule

// ----- rtl/ptl_scan.sv -----
`timescale 1ns / 1ps

`include "pdf_token_lexer_macros.svh"

module ptl_scan
    import ptl_pkg::*;
#(
    parameter int unsigned OFFSET_BITS = 32,
    parameter int unsigned DEPTH_BITS  = 8,
    parameter int unsigned VALUE_BITS  = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     take_i,
    input  in_item_t in_item_i,
    output batch_t   batch_o
);

    localparam int WIDE_BITS = VALUE_BITS + 4;
    localparam logic [VALUE_BITS-1:0]  VAL_MAX   = {1'b0, {(VALUE_BITS - 1){1'b1}}};
    localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX = {DEPTH_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0]  DEPTH_ONE = DEPTH_BITS'(1);
    localparam logic [OFFSET_BITS-1:0] OFF_ONE   = OFFSET_BITS'(1);

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_NAME,
        MODE_NUMBER,
        MODE_KEYWORD,
        MODE_STRING,
        MODE_LT,
        MODE_HEX,
        MODE_GT,
        MODE_DEAD
    } mode_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] acc;
        logic                  neg;
        logic                  pt;
        logic [4:0]            frac;
        logic [1:0]            fault;
    } num_t;

    mode_t                  mode_reg,  mode_next;
    logic [OFFSET_BITS-1:0] pos_reg,   pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [DEPTH_BITS-1:0]  depth_reg, depth_next;
    logic                   esc_reg,   esc_next;
    num_t                   num_reg,   num_next;

    logic [7:0]             c;
    logic [OFFSET_BITS-1:0] p;
    logic [OFFSET_BITS-1:0] len;
    logic                   do_idle;
    batch_t                 batch_v;

    function automatic num_t number_byte(num_t s, logic [7:0] ch, logic first);
        num_t                 r;
        logic [WIDE_BITS-1:0] wide;
        logic [3:0]           d;
        r    = s;
        d    = 4'(ch - CH_ZERO);
        wide = (WIDE_BITS'(s.acc) << 3) + (WIDE_BITS'(s.acc) << 1) + WIDE_BITS'(d);
        if (ch == CH_PLUS || ch == CH_MINUS) begin
            if (first) begin
                r.neg = (ch == CH_MINUS);
            end else begin
                r.fault = STATUS_INVALID;
            end
        end else if (ch == CH_POINT) begin
            if (s.pt) begin
                r.fault = STATUS_INVALID;
            end else begin
                r.pt = 1'b1;
            end
        end else begin
            if (wide > WIDE_BITS'(VAL_MAX)) begin
                r.acc = VAL_MAX;
                if (s.fault == STATUS_OK) begin
                    r.fault = STATUS_SAT;
                end
            end else begin
                r.acc = wide[VALUE_BITS-1:0];
            end
            if (s.pt && s.frac != FRAC_MAX) begin
                r.frac = s.frac + 5'd1;
            end
        end
        return r;
    endfunction

    function automatic result_t make_result(token_kind_t kind,
                                            logic [OFFSET_BITS-1:0] start,
                                            logic [OFFSET_BITS-1:0] length);
        result_t r;
        r              = '0;
        r.token_kind   = kind;
        r.start_offset = 32'(start);
        r.token_length = 32'(length);
        return r;
    endfunction

    function automatic result_t with_number(result_t base, num_t s);
        result_t                r;
        logic signed [VALUE_BITS-1:0] v;
        r = base;
        v = $signed(s.neg ? ('0 - s.acc) : s.acc);
        r.is_real       = s.pt;
        r.number_status = s.fault;
        if (s.fault != STATUS_INVALID) begin
            r.number_value    = 32'(v);
            r.fraction_digits = s.frac;
        end
        return r;
    endfunction

    function automatic batch_t push(batch_t b, result_t r);
        batch_t o;
        o = b;
        case (b.count)
            COUNT_BITS'(0): o.items[0] = r;
            COUNT_BITS'(1): o.items[1] = r;
            COUNT_BITS'(2): o.items[2] = r;
            default: ;
        endcase
        if (b.count != COUNT_BITS'(MAX_RESULTS)) begin
            o.count = b.count + COUNT_BITS'(1);
        end
        return o;
    endfunction

    function automatic batch_t mark_last(batch_t b);
        batch_t o;
        o = b;
        case (b.count)
            COUNT_BITS'(1): o.items[0].last_of_run = 1'b1;
            COUNT_BITS'(2): o.items[1].last_of_run = 1'b1;
            COUNT_BITS'(3): o.items[2].last_of_run = 1'b1;
            default: ;
        endcase
        return o;
    endfunction

    always_comb begin
        c          = in_item_i.data_byte;
        p          = pos_reg;
        len        = p + OFF_ONE - start_reg;
        mode_next  = mode_reg;
        start_next = start_reg;
        depth_next = depth_reg;
        esc_next   = esc_reg;
        num_next   = num_reg;
        batch_v    = '0;
        do_idle    = 1'b0;

        case (mode_reg)
            MODE_COMMENT: begin
                if (c == CH_LF || c == CH_CR) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_NAME, MODE_KEYWORD: begin
                if (is_space(c) || is_delim(c)) begin
                    batch_v = push(batch_v, make_result(
                        (mode_reg == MODE_NAME) ? KIND_NAME : KIND_KEYWORD,
                        start_reg, p - start_reg));
                    do_idle = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (is_numchar(c)) begin
                    num_next = number_byte(num_reg, c, 1'b0);
                end else begin
                    batch_v = push(batch_v, with_number(
                        make_result(KIND_NUMBER, start_reg, p - start_reg), num_reg));
                    do_idle = 1'b1;
                end
            end
            MODE_STRING: begin
                if (esc_reg) begin
                    esc_next = 1'b0;
                end else if (c == CH_BSLASH) begin
                    esc_next = 1'b1;
                end else if (c == CH_LPAREN) begin
                    if (depth_reg != DEPTH_MAX) begin
                        depth_next = depth_reg + DEPTH_ONE;
                    end
                end else if (c == CH_RPAREN) begin
                    depth_next = depth_reg - DEPTH_ONE;
                    if (depth_next == '0) begin
                        batch_v   = push(batch_v, make_result(KIND_STRING, start_reg, len));
                        mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_LT: begin
                if (c == CH_LT) begin
                    batch_v   = push(batch_v, make_result(KIND_DBEGIN, start_reg, len));
                    mode_next = MODE_IDLE;
                end else if (c == CH_GT) begin
                    batch_v   = push(batch_v, make_result(KIND_HEX, start_reg, len));
                    mode_next = MODE_IDLE;
                end else begin
                    mode_next = MODE_HEX;
                end
            end
            MODE_HEX: begin
                if (c == CH_GT) begin
                    batch_v   = push(batch_v, make_result(KIND_HEX, start_reg, len));
                    mode_next = MODE_IDLE;
                end
            end
            MODE_GT: begin
                if (c == CH_GT) begin
                    batch_v   = push(batch_v, make_result(KIND_DEND, start_reg, len));
                    mode_next = MODE_IDLE;
                end else begin
                    mode_next = MODE_DEAD;
                end
            end
            MODE_DEAD: begin
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // byte seen between tokens
        if (do_idle) begin
            mode_next  = MODE_IDLE;
            start_next = p;
            if (!is_space(c)) begin
                if (c == CH_PERCENT) begin
                    mode_next = MODE_COMMENT;
                end else if (c == CH_SLASH) begin
                    mode_next = MODE_NAME;
                end else if (is_numchar(c)) begin
                    mode_next = MODE_NUMBER;
                    num_next  = number_byte('0, c, 1'b1);
                end else if (c == CH_LPAREN) begin
                    mode_next  = MODE_STRING;
                    depth_next = DEPTH_ONE;
                    esc_next   = 1'b0;
                end else if (c == CH_LT) begin
                    mode_next = MODE_LT;
                end else if (c == CH_GT) begin
                    mode_next = MODE_GT;
                end else if (c == CH_LBRACK) begin
                    batch_v = push(batch_v, make_result(KIND_ABEGIN, p, OFF_ONE));
                end else if (c == CH_RBRACK) begin
                    batch_v = push(batch_v, make_result(KIND_AEND, p, OFF_ONE));
                end else if (c == CH_RPAREN || c == CH_LBRACE || c == CH_RBRACE) begin
                    mode_next = MODE_DEAD;
                end else begin
                    mode_next = MODE_KEYWORD;
                end
            end
        end

        pos_next = p + OFF_ONE;

        // end of stream: flush pending token, then the end marker
        if (in_item_i.stream_end) begin
            len = p + OFF_ONE - start_next;
            case (mode_next)
                MODE_NAME:    batch_v = push(batch_v, make_result(KIND_NAME, start_next, len));
                MODE_KEYWORD: batch_v = push(batch_v,
                                             make_result(KIND_KEYWORD, start_next, len));
                MODE_NUMBER:  batch_v = push(batch_v, with_number(
                                  make_result(KIND_NUMBER, start_next, len), num_next));
                MODE_STRING:  batch_v = push(batch_v,
                                             make_result(KIND_STRING, start_next, len));
                MODE_HEX:     batch_v = push(batch_v, make_result(KIND_HEX, start_next, len));
                MODE_LT, MODE_GT, MODE_DEAD: begin
                    batch_v = push(batch_v, make_result(KIND_BAD, start_next, len));
                end
                default: ;
            endcase
            batch_v   = push(batch_v, make_result(KIND_END, p + OFF_ONE, '0));
            mode_next = MODE_IDLE;
            pos_next  = '0;
        end

        batch_v = mark_last(batch_v);
    end

    assign batch_o = batch_v;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            pos_reg  <= '0;
        end else if (take_i) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
        end
        if (take_i) begin
            start_reg <= start_next;
            depth_reg <= depth_next;
            esc_reg   <= esc_next;
            num_reg   <= num_next;
        end
    end

    `PTL_ASSERT(a_end_always_emitted, aclk, aresetn, take_i && in_item_i.stream_end |-> batch_o.count != '0, "stream end without end result")
    `PTL_ASSERT_NEXT(a_end_restarts, aclk, aresetn, take_i && in_item_i.stream_end, pos_reg == '0 && mode_reg == MODE_IDLE, "stream end did not restart lexer")
    `PTL_ASSERT_NEXT(a_dead_holds, aclk, aresetn, take_i && mode_reg == MODE_DEAD && !in_item_i.stream_end, mode_reg == MODE_DEAD, "left bad token mode before stream end")

endmodule

// ----- rtl/ptl_out_queue.sv -----
`timescale 1ns / 1ps

`include "pdf_token_lexer_macros.svh"

module ptl_out_queue
    import ptl_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load_i,
    input  batch_t  batch_i,
    output logic    can_load_o,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t head_o
);

    result_t [MAX_RESULTS-1:0] slot_reg, slot_next;
    logic [COUNT_BITS-1:0]     count_reg, count_next;
    logic                      pop;

    assign m_tvalid   = count_reg != '0;
    assign pop        = m_tvalid && m_tready;
    assign can_load_o = (count_reg == '0) || (count_reg == COUNT_BITS'(1) && m_tready);
    assign head_o     = slot_reg[0];

    always_comb begin
        slot_next  = slot_reg;
        count_next = count_reg;
        if (pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                slot_next[i] = slot_reg[i + 1];
            end
            count_next = count_reg - COUNT_BITS'(1);
        end
        if (load_i) begin
            slot_next  = batch_i.items;
            count_next = batch_i.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        slot_reg <= slot_next;
    end

    `PTL_ASSERT(a_load_when_free, aclk, aresetn, load_i |-> count_reg == '0 || (count_reg == COUNT_BITS'(1) && m_tready), "batch loaded over pending results")
    `PTL_ASSERT_NEXT(a_pop_shifts, aclk, aresetn, pop && !load_i && count_reg == COUNT_BITS'(2), count_reg == COUNT_BITS'(1), "transfer did not retire one result")
    `PTL_ASSERT_NEXT(a_stall_keeps_count, aclk, aresetn, m_tvalid && !m_tready, count_reg == $past(count_reg), "result count changed while stalled")

endmodule

// ----- rtl/pdf_token_lexer.sv -----
`timescale 1ns / 1ps

// channel   dir  tdata                              tuser       tlast
// s_        in   [7:0] data_byte                    -           stream_end
// m_        out  start_offset, token_length,        token_kind  last_of_run
//                number_value, fraction_digits,
//                is_real, number_status
//
// one byte per cycle while m_ is ready; a byte with n results holds the input
// until its last result is sent; results pass input register and output queue
// input register takes a byte while results wait at the output queue
// aresetn clears control only; stalls on m_ stop the scanner, not the s_ register

module pdf_token_lexer
    import ptl_pkg::*;
#(
    parameter int unsigned OFFSET_BITS = 32,
    parameter int unsigned DEPTH_BITS  = 8,
    parameter int unsigned VALUE_BITS  = 32
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tlast,   // stream_end

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // start_offset, token_length, number_value,
                                    // fraction_digits, is_real, number_status
    output logic [3:0]   m_tuser,   // token_kind
    output logic         m_tlast    // last_of_run
);

    in_item_t s_item;
    in_item_t cur_item;
    logic     cur_valid;
    logic     can_load;
    logic     take;
    batch_t   batch;
    result_t  head;

    assign s_item.data_byte  = s_tdata;
    assign s_item.stream_end = s_tlast;
    assign take              = cur_valid && can_load;

    ptl_in_skid u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .take_i   (take),
        .valid_o  (cur_valid),
        .item_o   (cur_item)
    );

    ptl_scan #(
        .OFFSET_BITS (OFFSET_BITS),
        .DEPTH_BITS  (DEPTH_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take_i    (take),
        .in_item_i (cur_item),
        .batch_o   (batch)
    );

    ptl_out_queue u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_i     (take),
        .batch_i    (batch),
        .can_load_o (can_load),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .head_o     (head)
    );

    assign m_tdata = {head.number_status, head.is_real, head.fraction_digits,
                      head.number_value, head.token_length, head.start_offset};
    assign m_tuser = head.token_kind;
    assign m_tlast = head.last_of_run;

endmodule
